/* rtl/tts_pkg.sv */
// ----------------------------------------------------------------------------
// Transposition table store package
// Shared types and fixed constants for the direct-mapped search-result table.
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int KEY_W  = 64;
   localparam int FILL_W = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 15;

   localparam logic [7:0]  GENERATION_RESET     = 8'd0;
   localparam logic [14:0] MATE_THRESHOLD_RESET = 15'd31000;

   typedef enum logic [1:0] {
      ACT_PROBE = 2'd0,
      ACT_SAVE  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GENERATION     = 1'd0,
      CSR_MATE_THRESHOLD = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [KEY_W-1:0]  key;
      logic signed [15:0] score;
      logic [7:0]        bound;
      logic [7:0]        depth;
      logic [15:0]       move;
      logic signed [15:0] eval;
      logic [7:0]        ply;
   } req_payload_type;

   typedef struct packed {
      logic               hit;
      logic [15:0]        found_move;
      logic signed [15:0] found_score;
      logic signed [15:0] found_eval;
      logic [7:0]         found_depth;
      logic [7:0]         found_bound;
      logic [7:0]         found_generation;
      logic [FILL_W-1:0]  fill_permille;
   } rsp_payload_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [15:0]        move;
      logic signed [15:0] score;
      logic signed [15:0] eval;
      logic [7:0]         depth;
      logic [7:0]         bound;
      logic [7:0]         generation;
   } entry_type;

endpackage

/* rtl/tts_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/transposition_table_store.sv */
// ----------------------------------------------------------------------------
// Transposition table store
// Direct-mapped table of search results indexed by the low key bits, with
// probe, save with mate-score normalization and replacement, and full clear.
// ----------------------------------------------------------------------------
//   Channel  Ports                                  Direction  Handshake
//   request  start, busy, req_payload               in         start && !busy
//   result   rsp_valid, rsp_payload                 out        strobe, no stall
//   config   csr_we, csr_index, csr_wdata           in         write on csr_we
//
// One item per cycle unless busy; each passes a stage and a result register.
// The entry memory has one read and one write port; a write is forwarded to
// an item that read the same entry in the same cycle.
// A clear holds busy high while it is in the stage and while it sweeps the memory.
// After reset the memory is swept with busy high.
// ----------------------------------------------------------------------------
module transposition_table_store #(
   parameter int ENTRIES      = 4096,
   parameter int SAMPLE_SLOTS = 1000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  tts_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   output tts_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_we,
   input  logic [tts_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int ENTRY_W = $bits(tts_pkg::entry_type);
   localparam logic [IDX_W:0] SAMPLE_LIM = (IDX_W+1)'(SAMPLE_SLOTS);

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   state_type                     state_ff, state_in;
   logic [IDX_W-1:0]              clr_cnt_ff, clr_cnt_in;
   logic                          stage_vld_ff, stage_vld_in;
   tts_pkg::req_payload_type      stage_req_ff, stage_req_in;
   logic                          wr_en_ff, wr_en_in;
   logic [IDX_W-1:0]              wr_addr_ff, wr_addr_in;
   tts_pkg::entry_type            wr_data_ff, wr_data_in;
   logic [tts_pkg::FILL_W-1:0]    used_ff, used_in;
   logic [7:0]                    generation_ff, generation_in;
   logic [14:0]                   mate_threshold_ff, mate_threshold_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tts_pkg::rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   logic                          accept;
   logic                          stage_clear;
   logic [IDX_W-1:0]              stage_idx;
   logic [ENTRY_W-1:0]            ram_rdata;
   tts_pkg::entry_type            cur;
   tts_pkg::entry_type            new_entry;
   logic                          ram_we;
   logic [IDX_W-1:0]              ram_waddr;
   tts_pkg::entry_type            ram_wdata;
   logic signed [16:0]            score_wide;
   logic signed [16:0]            bound_pos;
   logic signed [15:0]            adj_score;
   logic                          replace;
   logic                          sample_slot;

   assign stage_clear = stage_vld_ff && (stage_req_ff.action == tts_pkg::ACT_CLEAR);
   assign busy        = (state_ff == ST_CLEAR) || stage_clear;
   assign accept      = start && !busy;
   assign stage_idx   = stage_req_ff.key[IDX_W-1:0];

   tts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (req_payload.key[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (wr_en_ff && (wr_addr_ff == stage_idx)) begin
         cur = wr_data_ff;
      end else begin
         cur = tts_pkg::entry_type'(ram_rdata);
      end

      score_wide = {stage_req_ff.score[15], stage_req_ff.score};
      bound_pos  = $signed({2'b00, mate_threshold_ff});
      if (score_wide > bound_pos) begin
         adj_score = stage_req_ff.score + $signed({8'd0, stage_req_ff.ply});
      end else if (score_wide < -bound_pos) begin
         adj_score = stage_req_ff.score - $signed({8'd0, stage_req_ff.ply});
      end else begin
         adj_score = stage_req_ff.score;
      end

      replace = !cur.valid || (cur.key != stage_req_ff.key) ||
                (stage_req_ff.depth >= cur.depth) || (cur.generation != generation_ff);
      sample_slot = ({1'b0, stage_idx} < SAMPLE_LIM);

      new_entry.valid      = 1'b1;
      new_entry.key        = stage_req_ff.key;
      new_entry.move       = stage_req_ff.move;
      new_entry.score      = adj_score;
      new_entry.eval       = stage_req_ff.eval;
      new_entry.depth      = stage_req_ff.depth;
      new_entry.bound      = stage_req_ff.bound;
      new_entry.generation = generation_ff;
   end

   always_comb begin
      state_in          = state_ff;
      clr_cnt_in        = clr_cnt_ff;
      stage_vld_in      = accept;
      stage_req_in      = req_payload;
      used_in           = used_ff;
      generation_in     = generation_ff;
      mate_threshold_in = mate_threshold_ff;
      rsp_valid_in      = stage_vld_ff;
      rsp_payload_in    = '0;
      ram_we            = 1'b0;
      ram_waddr         = stage_idx;
      ram_wdata         = new_entry;

      if (csr_we) begin
         case (tts_pkg::csr_index_type'(csr_index))
            tts_pkg::CSR_GENERATION: generation_in = csr_wdata[7:0];
            tts_pkg::CSR_MATE_THRESHOLD: mate_threshold_in = csr_wdata[14:0];
            default: ;
         endcase
      end

      if (state_ff == ST_CLEAR) begin
         ram_we     = 1'b1;
         ram_waddr  = clr_cnt_ff;
         ram_wdata  = '0;
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (&clr_cnt_ff) begin
            state_in = ST_RUN;
         end
      end else if (stage_vld_ff) begin
         case (stage_req_ff.action)
            tts_pkg::ACT_PROBE: begin
               rsp_payload_in.hit              = cur.valid && (cur.key == stage_req_ff.key);
               rsp_payload_in.found_move       = cur.move;
               rsp_payload_in.found_score      = cur.score;
               rsp_payload_in.found_eval       = cur.eval;
               rsp_payload_in.found_depth      = cur.depth;
               rsp_payload_in.found_bound      = cur.bound;
               rsp_payload_in.found_generation = cur.generation;
               rsp_payload_in.fill_permille    = used_ff;
            end
            tts_pkg::ACT_SAVE: begin
               if (replace) begin
                  ram_we = 1'b1;
                  if (!cur.valid && sample_slot) begin
                     used_in = used_ff + 1'b1;
                  end
                  rsp_payload_in.hit              = 1'b1;
                  rsp_payload_in.found_move       = new_entry.move;
                  rsp_payload_in.found_score      = new_entry.score;
                  rsp_payload_in.found_eval       = new_entry.eval;
                  rsp_payload_in.found_depth      = new_entry.depth;
                  rsp_payload_in.found_bound      = new_entry.bound;
                  rsp_payload_in.found_generation = new_entry.generation;
               end else begin
                  rsp_payload_in.found_move       = cur.move;
                  rsp_payload_in.found_score      = cur.score;
                  rsp_payload_in.found_eval       = cur.eval;
                  rsp_payload_in.found_depth      = cur.depth;
                  rsp_payload_in.found_bound      = cur.bound;
                  rsp_payload_in.found_generation = cur.generation;
               end
               rsp_payload_in.fill_permille = used_in;
            end
            tts_pkg::ACT_CLEAR: begin
               used_in    = '0;
               state_in   = ST_CLEAR;
               clr_cnt_in = '0;
            end
            default: begin
               rsp_payload_in.fill_permille = used_ff;
            end
         endcase
      end

      wr_en_in   = ram_we;
      wr_addr_in = ram_waddr;
      wr_data_in = ram_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clr_cnt_ff        <= '0;
         stage_vld_ff      <= 1'b0;
         wr_en_ff          <= 1'b0;
         used_ff           <= '0;
         generation_ff     <= tts_pkg::GENERATION_RESET;
         mate_threshold_ff <= tts_pkg::MATE_THRESHOLD_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clr_cnt_ff        <= clr_cnt_in;
         stage_vld_ff      <= stage_vld_in;
         stage_req_ff      <= stage_req_in;
         wr_en_ff          <= wr_en_in;
         wr_addr_ff        <= wr_addr_in;
         wr_data_ff        <= wr_data_in;
         used_ff           <= used_in;
         generation_ff     <= generation_in;
         mate_threshold_ff <= mate_threshold_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_payload_ff    <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A clear beat starts the sweep and reports an empty table.
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      stage_clear |=> (state_ff == ST_CLEAR) && rsp_valid_ff &&
                      (rsp_payload_ff == '0))
      else $error("clear beat did not start the sweep with an empty result");

   // The sweep writes empty entries on every cycle.
   a_sweep_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> ram_we && (ram_wdata == '0))
      else $error("sweep cycle without an empty-entry write");

   // The used-slot count never exceeds the sampled range.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, used_ff} <= (tts_pkg::FILL_W+1)'(SAMPLE_SLOTS))
      else $error("used-slot count out of range");

   // No item sits in the stage while the sweep runs.
   a_no_item_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && $past(state_ff == ST_CLEAR) |-> !stage_vld_ff)
      else $error("item in flight during sweep");

endmodule

/* test/transposition_table_store_checker.sv */
// ----------------------------------------------------------------------------
// Transposition table store checker
// Watches the request, result and register ports of the table, keeps its own
// image of every slot and of the register settings, works out the result of
// each accepted request beat and compares each result beat, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module transposition_table_store_checker #(
   parameter int ENTRIES      = 4096,
   parameter int SAMPLE_SLOTS = 1000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  tts_pkg::req_payload_type            req_payload,
   input  logic                                rsp_valid,
   input  tts_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_we,
   input  logic [tts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  pending_count
);

   localparam int INDEX_W = $clog2(ENTRIES);

   tts_pkg::entry_type         table_image [ENTRIES];
   int                         used_samples;
   logic [7:0]                 search_generation;
   logic [14:0]                mate_threshold;
   tts_pkg::rsp_payload_type   awaited_lookups [$];
   tts_pkg::rsp_payload_type   oldest;
   int                         error_total;

   initial begin
      error_total   = 0;
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic tts_pkg::rsp_payload_type table_access_result(
      input tts_pkg::req_payload_type beat);
      tts_pkg::rsp_payload_type  outcome;
      tts_pkg::entry_type        slot;
      logic [INDEX_W-1:0]        index;
      int                        adjusted;
      logic                      replace;
      outcome = '0;
      index   = beat.key[INDEX_W-1:0];
      slot    = table_image[index];
      case (beat.action)
         tts_pkg::ACT_PROBE: begin
            outcome.hit = slot.valid && (slot.key == beat.key);
         end
         tts_pkg::ACT_SAVE: begin
            adjusted = int'(beat.score);
            if (adjusted > int'(mate_threshold)) begin
               adjusted = adjusted + int'(beat.ply);
            end else if (adjusted < -int'(mate_threshold)) begin
               adjusted = adjusted - int'(beat.ply);
            end
            replace = !slot.valid || (slot.key != beat.key) ||
                      (beat.depth >= slot.depth) ||
                      (slot.generation != search_generation);
            if (replace) begin
               if (!slot.valid && (index < SAMPLE_SLOTS)) begin
                  used_samples++;
               end
               slot.valid      = 1'b1;
               slot.key        = beat.key;
               slot.move       = beat.move;
               slot.score      = adjusted[15:0];
               slot.eval       = beat.eval;
               slot.depth      = beat.depth;
               slot.bound      = beat.bound;
               slot.generation = search_generation;
               table_image[index] = slot;
            end
            outcome.hit = replace;
         end
         tts_pkg::ACT_CLEAR: begin
            foreach (table_image[i]) begin
               table_image[i] = '0;
            end
            used_samples = 0;
         end
         default: begin
         end
      endcase
      if ((beat.action == tts_pkg::ACT_PROBE) || (beat.action == tts_pkg::ACT_SAVE)) begin
         outcome.found_move       = slot.move;
         outcome.found_score      = slot.score;
         outcome.found_eval       = slot.eval;
         outcome.found_depth      = slot.depth;
         outcome.found_bound      = slot.bound;
         outcome.found_generation = slot.generation;
      end
      outcome.fill_permille = used_samples[tts_pkg::FILL_W-1:0];
      return outcome;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (table_image[i]) begin
            table_image[i] = '0;
         end
         used_samples      = 0;
         search_generation = tts_pkg::GENERATION_RESET;
         mate_threshold    = tts_pkg::MATE_THRESHOLD_RESET;
         awaited_lookups.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_lookups.size() == 0) begin
               $display("%0t: result beat with no request outstanding, actual %h",
                        $time, rsp_payload);
               error_total++;
            end else begin
               oldest = awaited_lookups.pop_front();
               compare_field("hit", oldest.hit, rsp_payload.hit);
               compare_field("found_move", oldest.found_move, rsp_payload.found_move);
               compare_field("found_score", oldest.found_score, rsp_payload.found_score);
               compare_field("found_eval", oldest.found_eval, rsp_payload.found_eval);
               compare_field("found_depth", oldest.found_depth, rsp_payload.found_depth);
               compare_field("found_bound", oldest.found_bound, rsp_payload.found_bound);
               compare_field("found_generation", oldest.found_generation,
                             rsp_payload.found_generation);
               compare_field("fill_permille", oldest.fill_permille,
                             rsp_payload.fill_permille);
            end
         end
         if (start && !busy) begin
            awaited_lookups.push_back(table_access_result(req_payload));
         end
         if (csr_we) begin
            case (csr_index)
               tts_pkg::CSR_GENERATION: search_generation = csr_wdata[7:0];
               tts_pkg::CSR_MATE_THRESHOLD: mate_threshold = csr_wdata[14:0];
               default: begin
               end
            endcase
         end
      end
      fail_count    <= error_total;
      pending_count <= awaited_lookups.size();
   end

endmodule

/* test/transposition_table_store_test.sv */
// ----------------------------------------------------------------------------
// Transposition table store testbench
// Drives probes, saves, clears and the unused action code into the table,
// first as a directed sequence over the replacement, mate-score and clear
// rules, then as random phases under changing register settings, with
// random gaps between beats. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module transposition_table_store_test;

   localparam int          ENTRIES      = 4096;
   localparam int          SAMPLE_SLOTS = 1000;
   localparam int          POOL_SIZE    = 24;
   localparam int          PHASES       = 6;
   localparam int          PHASE_BEATS  = 100;
   localparam int          STALL_LIMIT  = 20000;
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   tts_pkg::req_payload_type            req_payload;
   logic                                rsp_valid;
   tts_pkg::rsp_payload_type            rsp_payload;
   logic                                csr_we;
   logic [tts_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [tts_pkg::CSR_DATA_W-1:0]      csr_wdata;
   int                                  fail_count;
   int                                  pending_count;

   logic [63:0]              key_pool [POOL_SIZE];
   int                       mate_limit;
   int                       stall_cycles;

   transposition_table_store #(
      .ENTRIES      (ENTRIES),
      .SAMPLE_SLOTS (SAMPLE_SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   transposition_table_store_checker #(
      .ENTRIES      (ENTRIES),
      .SAMPLE_SLOTS (SAMPLE_SLOTS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic tts_pkg::req_payload_type compose_beat(
      input logic [1:0] action, input logic [63:0] key, input logic [15:0] score,
      input logic [7:0] bound, input logic [7:0] depth, input logic [15:0] move,
      input logic [15:0] eval, input logic [7:0] ply);
      tts_pkg::req_payload_type beat;
      beat.action = action;
      beat.key    = key;
      beat.score  = score;
      beat.bound  = bound;
      beat.depth  = depth;
      beat.move   = move;
      beat.eval   = eval;
      beat.ply    = ply;
      return beat;
   endfunction

   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 3) != 0) begin
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [15:0] pick_score();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(mate_limit);
         3: return 16'(mate_limit + 1);
         4: return 16'(-mate_limit);
         5: return 16'(-mate_limit - 1);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic tts_pkg::req_payload_type random_beat();
      int          pick;
      logic [1:0]  action;
      pick = $urandom_range(0, 999);
      if (pick < 450) begin
         action = tts_pkg::ACT_PROBE;
      end else if (pick < 930) begin
         action = tts_pkg::ACT_SAVE;
      end else if (pick < 993) begin
         action = ACT_UNUSED;
      end else begin
         action = tts_pkg::ACT_CLEAR;
      end
      return compose_beat(action, pick_key(), pick_score(), 8'($urandom()),
                          8'($urandom()), 16'($urandom()), 16'($urandom()),
                          8'($urandom()));
   endfunction

   task automatic issue_beat(input tts_pkg::req_payload_type beat, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      do @(posedge clock); while ((pending_count != 0) || busy);
   endtask

   task automatic settle_and_configure(input logic [7:0] generation,
                                       input logic [14:0] bound_value);
      wait_until_drained();
      csr_we    <= 1'b1;
      csr_index <= tts_pkg::CSR_GENERATION;
      csr_wdata <= tts_pkg::CSR_DATA_W'(generation);
      @(posedge clock);
      csr_index <= tts_pkg::CSR_MATE_THRESHOLD;
      csr_wdata <= bound_value;
      @(posedge clock);
      csr_we     <= 1'b0;
      mate_limit  = bound_value;
   endtask

   task automatic directed_beat(input tts_pkg::req_payload_type beat);
      issue_beat(beat, $urandom_range(0, 7));
   endtask

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [7:0] generation;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      mate_limit  = tts_pkg::MATE_THRESHOLD_RESET;
      key_pool[0] = '0;
      for (int i = 1; i < POOL_SIZE; i++) begin
         key_pool[i] = {$urandom(), $urandom()};
         case (i % 6)
            0: key_pool[i][11:0] = 12'd0;
            1: key_pool[i][11:0] = 12'd999;
            2: key_pool[i][11:0] = 12'd1000;
            3: key_pool[i][11:0] = 12'd4095;
            4: key_pool[i][11:0] = 12'(i);
            default: key_pool[i][11:0] = 12'($urandom_range(0, 4095));
         endcase
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      settle_and_configure(tts_pkg::GENERATION_RESET, tts_pkg::MATE_THRESHOLD_RESET);
      directed_beat(compose_beat(tts_pkg::ACT_PROBE, 64'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                 16'h0, 8'h0));
      directed_beat(compose_beat(ACT_UNUSED, 64'h0, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
                                 16'hFFFF, 8'hFF));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h0, 16'd100, 8'h01, 8'd5, 16'hFFFF,
                                 16'h8000, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_PROBE, 64'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                 16'h0, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h0, 16'd7, 8'h02, 8'd4, 16'h1234,
                                 16'h0001, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h0, 16'd8, 8'h03, 8'd5, 16'h4321,
                                 16'h0002, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h1000, 16'd9, 8'h04, 8'd0, 16'h5555,
                                 16'h0003, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_PROBE, 64'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                 16'h0, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFF,
                                 8'hFF, 8'hFF, 16'h0000, 16'h7FFF, 8'hFF));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'd999, 16'h8000, 8'h10, 8'd0,
                                 16'hAAAA, 16'hFFFF, 8'hFF));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'd1000, 16'd31001, 8'h20, 8'd3,
                                 16'hBBBB, 16'h0100, 8'd3));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'd999, -16'sd31000, 8'h30, 8'd0,
                                 16'hCCCC, 16'h0200, 8'd7));
      directed_beat(compose_beat(tts_pkg::ACT_PROBE, 64'd1000, 16'h0, 8'h0, 8'h0, 16'h0,
                                 16'h0, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_CLEAR, 64'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                 16'h0, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_PROBE, 64'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                 16'h0, 8'h0));
      directed_beat(compose_beat(tts_pkg::ACT_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 8'h0,
                                 8'h0, 16'h0, 16'h0, 8'h0));

      settle_and_configure(8'd255, 15'd0);
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h5, 16'd1, 8'h01, 8'd200, 16'h0101,
                                 16'h0011, 8'd9));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h5, 16'hFFFF, 8'h02, 8'd100,
                                 16'h0202, 16'h0022, 8'd9));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h5, 16'd0, 8'h03, 8'd200, 16'h0303,
                                 16'h0033, 8'd9));

      settle_and_configure(8'd7, 15'd32767);
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h5, 16'h8000, 8'h04, 8'd0, 16'h0404,
                                 16'h0044, 8'd255));
      directed_beat(compose_beat(tts_pkg::ACT_SAVE, 64'h5, 16'h7FFF, 8'h05, 8'd0, 16'h0505,
                                 16'h0055, 8'd1));
      directed_beat(compose_beat(tts_pkg::ACT_PROBE, 64'h5, 16'h0, 8'h0, 8'h0, 16'h0,
                                 16'h0, 8'h0));

      generation = 8'd0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               generation = 8'd255;
               settle_and_configure(generation, tts_pkg::MATE_THRESHOLD_RESET);
            end
            1: begin
               generation = 8'd0;
               settle_and_configure(generation, 15'd0);
            end
            2: begin
               generation = 8'($urandom());
               settle_and_configure(generation, 15'd32767);
            end
            3: begin
               generation = 8'($urandom());
               settle_and_configure(generation, 15'($urandom()));
            end
            4: settle_and_configure(generation, 15'($urandom_range(0, 300)));
            default: begin
               generation = 8'($urandom());
               settle_and_configure(generation, tts_pkg::MATE_THRESHOLD_RESET);
            end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            issue_beat(random_beat(), ((n % 40) < 12) ? 0 : $urandom_range(0, 7));
         end
      end

      wait_until_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
